FILE: design/ccfc_pkg.sv
// shared types, register indexes and reject codes for the can control frame checker
// used by every module of the block; no dependencies

package ccfc_pkg;

  localparam int NumStages = 9;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);

  localparam logic [2:0] REG_FRAME_ID   = 3'd0;
  localparam logic [2:0] REG_CRC_POLY   = 3'd1;
  localparam logic [2:0] REG_CRC_INIT   = 3'd2;
  localparam logic [2:0] REG_CRC_XOR    = 3'd3;
  localparam logic [2:0] REG_SPEED_MIN  = 3'd4;
  localparam logic [2:0] REG_SPEED_MAX  = 3'd5;
  localparam logic [2:0] REG_YAW_MIN    = 3'd6;
  localparam logic [2:0] REG_YAW_MAX    = 3'd7;

  localparam logic [3:0] RSN_NONE      = 4'd0;
  localparam logic [3:0] RSN_ID        = 4'd1;
  localparam logic [3:0] RSN_LENGTH    = 4'd2;
  localparam logic [3:0] RSN_EXTENDED  = 4'd3;
  localparam logic [3:0] RSN_REMOTE    = 4'd4;
  localparam logic [3:0] RSN_RESERVED  = 4'd5;
  localparam logic [3:0] RSN_CMD_VALID = 4'd6;
  localparam logic [3:0] RSN_CRC       = 4'd7;
  localparam logic [3:0] RSN_MODE      = 4'd8;
  localparam logic [3:0] RSN_RANGE     = 4'd9;
  localparam logic [3:0] RSN_HOLD      = 4'd10;

  localparam logic [3:0] CtrlLength = 4'd8;
  localparam logic [7:0] CmdValidByte = 8'h01;

  typedef struct packed {
    logic [10:0]        frame_id;
    logic [7:0]         crc_poly;
    logic [7:0]         crc_init;
    logic [7:0]         crc_xor;
    logic signed [15:0] speed_min;
    logic signed [15:0] speed_max;
    logic signed [15:0] yaw_min;
    logic signed [15:0] yaw_max;
  } cfg_t;

  // frame in flight through the crc stages
  typedef struct packed {
    logic [3:0]  reason;
    logic [7:0]  id_hi;
    logic [7:0]  crc;
    logic [63:0] payload;
  } stage_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic [3:0]  reason;
    logic [7:0]  crc;
    logic [63:0] payload;
  } item_t;

endpackage

FILE: design/ccfc_if.sv
// valid/ready channel interfaces for received frames and check results
// no dependencies

interface ccfc_frame_if;
  logic        valid;
  logic        ready;
  logic [28:0] frame_id;
  logic [3:0]  frame_length;
  logic        extended_flag;
  logic        remote_flag;
  logic [63:0] payload;

  modport source(output valid, frame_id, frame_length, extended_flag, remote_flag, payload,
                 input ready);
  modport sink(input valid, frame_id, frame_length, extended_flag, remote_flag, payload,
               output ready);
endinterface

interface ccfc_result_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [3:0]         reject_reason;
  logic               mode;
  logic signed [15:0] speed_raw;
  logic signed [15:0] yaw_raw;
  logic [3:0]         rolling_count;

  modport source(output valid, accepted, reject_reason, mode, speed_raw, yaw_raw,
                 rolling_count, input ready);
  modport sink(input valid, accepted, reject_reason, mode, speed_raw, yaw_raw,
               rolling_count, output ready);
endinterface

FILE: design/ccfc_front.sv
// front: takes frames, flags header faults and runs the crc one byte per stage
// depends on ccfc_pkg and ccfc_if

module ccfc_front
  import ccfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  ccfc_frame_if.sink    frame,
  output logic          push_valid,
  input  logic          push_ready,
  output item_t         push_item
);

  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic   vld [NumStages];
  stage_t stg [NumStages];
  logic   advance;
  logic [3:0] in_reason;
  stage_t in_stage;
  logic [7:0] crc_next [NumStages];

  // whole pipe moves unless the last stage is blocked by a full queue
  assign advance = !vld[NumStages-1] || push_ready;
  assign frame.ready = advance;

  always_comb begin
    if (frame.frame_id != {18'd0, cfg.frame_id}) begin
      in_reason = RSN_ID;
    end else if (frame.frame_length != CtrlLength) begin
      in_reason = RSN_LENGTH;
    end else if (frame.extended_flag) begin
      in_reason = RSN_EXTENDED;
    end else if (frame.remote_flag) begin
      in_reason = RSN_REMOTE;
    end else if (frame.payload[47:44] != 4'd0 || frame.payload[55:49] != 7'd0) begin
      in_reason = RSN_RESERVED;
    end else if (frame.payload[55:48] != CmdValidByte) begin
      in_reason = RSN_CMD_VALID;
    end else begin
      in_reason = RSN_NONE;
    end
  end

  always_comb begin
    in_stage.reason  = in_reason;
    in_stage.id_hi   = frame.frame_id[15:8];
    in_stage.crc     = crc_byte(cfg.crc_init, frame.frame_id[7:0], cfg.crc_poly);
    in_stage.payload = frame.payload;
  end

  // stage 1 folds in the id high byte, stages 2..8 fold in payload bytes 0..6
  always_comb begin
    crc_next[0] = in_stage.crc;
    crc_next[1] = crc_byte(stg[0].crc, stg[0].id_hi, cfg.crc_poly);
    for (int k = 2; k < NumStages; k++) begin
      crc_next[k] = crc_byte(stg[k-1].crc, stg[k-1].payload[8*(k-2) +: 8], cfg.crc_poly);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumStages; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (advance) begin
      vld[0] <= frame.valid;
      for (int k = 1; k < NumStages; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg[0] <= '{reason: in_stage.reason, id_hi: in_stage.id_hi, crc: crc_next[0],
                  payload: in_stage.payload};
      for (int k = 1; k < NumStages; k++) begin
        stg[k] <= '{reason: stg[k-1].reason, id_hi: stg[k-1].id_hi, crc: crc_next[k],
                    payload: stg[k-1].payload};
      end
    end
  end

  assign push_valid        = vld[NumStages-1];
  assign push_item.reason  = stg[NumStages-1].reason;
  assign push_item.crc     = stg[NumStages-1].crc;
  assign push_item.payload = stg[NumStages-1].payload;

endmodule

FILE: design/ccfc_queue.sv
// short fifo of classified frames between front and back
// depends on ccfc_pkg

module ccfc_queue
  import ccfc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  item_t mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != QueueDepth[QueuePtrW:0]);
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: design/ccfc_back.sv
// back: crc compare, mode and limit checks, registered result beat
// depends on ccfc_pkg and ccfc_if

module ccfc_back
  import ccfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          pop_valid,
  output logic          pop,
  input  item_t         pop_item,
  ccfc_result_if.source result
);

  logic [7:0]         mode_byte;
  logic signed [15:0] spd;
  logic signed [15:0] yaw;
  logic [3:0]         reason;
  logic               out_vld;

  assign mode_byte = pop_item.payload[39:32];
  assign spd       = pop_item.payload[15:0];
  assign yaw       = pop_item.payload[31:16];

  always_comb begin
    if (pop_item.reason != RSN_NONE) begin
      reason = pop_item.reason;
    end else if (pop_item.payload[63:56] != (pop_item.crc ^ cfg.crc_xor)) begin
      reason = RSN_CRC;
    end else if (mode_byte > 8'd1) begin
      reason = RSN_MODE;
    end else if (spd < cfg.speed_min || spd > cfg.speed_max ||
                 yaw < cfg.yaw_min || yaw > cfg.yaw_max) begin
      reason = RSN_RANGE;
    end else if (mode_byte == 8'd0 && (spd != 16'sd0 || yaw != 16'sd0)) begin
      reason = RSN_HOLD;
    end else begin
      reason = RSN_NONE;
    end
  end

  // output register takes a new beat when empty or being drained
  assign pop          = pop_valid && (!out_vld || result.ready);
  assign result.valid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (!out_vld || result.ready) begin
      out_vld <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.reject_reason <= reason;
      if (reason == RSN_NONE) begin
        result.accepted      <= 1'b1;
        result.mode          <= mode_byte[0];
        result.speed_raw     <= spd;
        result.yaw_raw       <= yaw;
        result.rolling_count <= pop_item.payload[43:40];
      end else begin
        result.accepted      <= 1'b0;
        result.mode          <= 1'b0;
        result.speed_raw     <= '0;
        result.yaw_raw       <= '0;
        result.rolling_count <= '0;
      end
    end
  end

endmodule

FILE: design/can_control_frame_checker_unit.sv
// top level of the can control frame checker: config registers, front, queue, back
// depends on ccfc_pkg, ccfc_if, ccfc_front, ccfc_queue and ccfc_back
//
//   port      dir  kind                 beat
//   frame     in   ccfc_frame_if.sink   one received can frame
//   result    out  ccfc_result_if.src   accept flag, reject reason and decoded fields
//   cfg_*     in   write port           one register write per cycle with cfg_we
//
// one frame per cycle sustained while the result side is ready; a frame passes through the
// byte-wide crc stages, then the queue, then the result register before its result.
// rst is synchronous; it clears pipe valids, queue pointers and the result valid, and loads config defaults.
// a stalled result fills the 4-entry queue first; only then does frame.ready drop.

module can_control_frame_checker_unit
  import ccfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ccfc_frame_if.sink    frame,
  ccfc_result_if.source result,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  cfg_t  cfg;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_id  <= '0;
      cfg.crc_poly  <= 8'h1d;
      cfg.crc_init  <= 8'hff;
      cfg.crc_xor   <= 8'hff;
      cfg.speed_min <= 16'sh8000;
      cfg.speed_max <= 16'sh7fff;
      cfg.yaw_min   <= 16'sh8000;
      cfg.yaw_max   <= 16'sh7fff;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_ID:  cfg.frame_id  <= cfg_data[10:0];
        REG_CRC_POLY:  cfg.crc_poly  <= cfg_data[7:0];
        REG_CRC_INIT:  cfg.crc_init  <= cfg_data[7:0];
        REG_CRC_XOR:   cfg.crc_xor   <= cfg_data[7:0];
        REG_SPEED_MIN: cfg.speed_min <= cfg_data;
        REG_SPEED_MAX: cfg.speed_max <= cfg_data;
        REG_YAW_MIN:   cfg.yaw_min   <= cfg_data;
        REG_YAW_MAX:   cfg.yaw_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  ccfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .frame     (frame),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  ccfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  ccfc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pop_valid(pop_valid),
    .pop      (pop),
    .pop_item (pop_item),
    .result   (result)
  );

endmodule

FILE: sim/ccfc_tb_pkg.sv
// testbench types and the crc used to seal and to judge control frames
// depends on ccfc_pkg (cfg_t)

package ccfc_tb_pkg;
  import ccfc_pkg::*;

  typedef struct packed {
    logic [28:0] id;
    logic [3:0]  len;
    logic        ext;
    logic        rtr;
    logic [63:0] payload;
  } can_frame_t;

  typedef struct packed {
    logic               accepted;
    logic [3:0]         reason;
    logic               mode;
    logic signed [15:0] speed;
    logic signed [15:0] yaw;
    logic [3:0]         count;
  } verdict_t;

  localparam cfg_t DefaultSetting = '{11'd0, 8'h1D, 8'hFF, 8'hFF,
                                      16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};

  // msb-first crc over id low byte, id bits 15..8, then payload bytes 0..6
  function automatic logic [7:0] frame_crc(logic [28:0] id, logic [63:0] payload, cfg_t s);
    logic [7:0]  c;
    logic [71:0] stream;
    c = s.crc_init;
    stream = {payload[55:0], id[15:8], id[7:0]};
    for (int n = 0; n < 9; n++) begin
      c = c ^ stream[8*n +: 8];
      for (int k = 0; k < 8; k++) begin
        c = c[7] ? ((c << 1) ^ s.crc_poly) : (c << 1);
      end
    end
    return c ^ s.crc_xor;
  endfunction

endpackage

FILE: sim/ccfc_verdict_monitor.sv
// watches the frame and result channels, predicts each frame's verdict and compares
// depends on ccfc_pkg, ccfc_tb_pkg and the ccfc_frame_if / ccfc_result_if interfaces

module ccfc_verdict_monitor
  import ccfc_pkg::*;
  import ccfc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ccfc_frame_if       frame,
  ccfc_result_if      result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          checked,
  output int          passed,
  output int          fail_count
);

  cfg_t     cfg;
  verdict_t due_verdicts[$];

  function automatic verdict_t judge_frame(can_frame_t f, cfg_t c);
    verdict_t           v;
    logic [7:0]         b [8];
    logic [3:0]         why;
    logic signed [15:0] spd;
    logic signed [15:0] yaw;
    for (int n = 0; n < 8; n++) b[n] = f.payload[8*n +: 8];
    spd = {b[1], b[0]};
    yaw = {b[3], b[2]};
    if (f.id != {18'd0, c.frame_id}) why = RSN_ID;
    else if (f.len != CtrlLength) why = RSN_LENGTH;
    else if (f.ext) why = RSN_EXTENDED;
    else if (f.rtr) why = RSN_REMOTE;
    else if (b[5][7:4] != 4'd0 || b[6][7:1] != 7'd0) why = RSN_RESERVED;
    else if (b[6] != CmdValidByte) why = RSN_CMD_VALID;
    else if (b[7] != frame_crc(f.id, f.payload, c)) why = RSN_CRC;
    else if (b[4] > 8'd1) why = RSN_MODE;
    else if (spd < $signed(c.speed_min) || spd > $signed(c.speed_max) ||
             yaw < $signed(c.yaw_min) || yaw > $signed(c.yaw_max)) why = RSN_RANGE;
    else if (b[4] == 8'd0 && (spd != 16'sd0 || yaw != 16'sd0)) why = RSN_HOLD;
    else why = RSN_NONE;
    v = '0;
    v.reason = why;
    if (why == RSN_NONE) begin
      v.accepted = 1'b1;
      v.mode     = b[4][0];
      v.speed    = spd;
      v.yaw      = yaw;
      v.count    = b[5][3:0];
    end
    return v;
  endfunction

  function automatic string show(verdict_t v);
    return $sformatf("acc=%0d rsn=%0d mode=%0d spd=%0d yaw=%0d cnt=%0d",
                     v.accepted, v.reason, v.mode, v.speed, v.yaw, v.count);
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    verdict_t got;
    string    bad;
    if (rst) begin
      cfg <= DefaultSetting;
      due_verdicts.delete();
      pending    <= 0;
      checked    <= 0;
      passed     <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_ID:  cfg.frame_id  <= cfg_data[10:0];
          REG_CRC_POLY:  cfg.crc_poly  <= cfg_data[7:0];
          REG_CRC_INIT:  cfg.crc_init  <= cfg_data[7:0];
          REG_CRC_XOR:   cfg.crc_xor   <= cfg_data[7:0];
          REG_SPEED_MIN: cfg.speed_min <= cfg_data;
          REG_SPEED_MAX: cfg.speed_max <= cfg_data;
          REG_YAW_MIN:   cfg.yaw_min   <= cfg_data;
          REG_YAW_MAX:   cfg.yaw_max   <= cfg_data;
          default: ;
        endcase
      end
      // compare before pushing so a same-edge frame never matches its own result
      if (result.valid && result.ready) begin
        got = {result.accepted, result.reject_reason, result.mode,
               result.speed_raw, result.yaw_raw, result.rolling_count};
        if (due_verdicts.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result beat: %s", show(got));
        end else begin
          want = due_verdicts.pop_front();
          bad = "";
          if (got.accepted !== want.accepted) bad = {bad, " accepted"};
          if (got.reason !== want.reason) bad = {bad, " reject_reason"};
          if (got.mode !== want.mode) bad = {bad, " mode"};
          if (got.speed !== want.speed) bad = {bad, " speed_raw"};
          if (got.yaw !== want.yaw) bad = {bad, " yaw_raw"};
          if (got.count !== want.count) bad = {bad, " rolling_count"};
          checked <= checked + 1;
          if (want.accepted) passed <= passed + 1;
          if (bad != "") begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch in%s: expected %s, got %s", bad, show(want), show(got));
          end
        end
      end
      if (frame.valid && frame.ready)
        due_verdicts.push_back(judge_frame({frame.frame_id, frame.frame_length,
                                            frame.extended_flag, frame.remote_flag,
                                            frame.payload}, cfg));
      pending <= due_verdicts.size();
    end
  end

endmodule

FILE: sim/tb_can_control_frame_checker_unit.sv
// top of the frame checker testbench: clock, reset, register writes, frame stimulus
// and result stalls; depends on ccfc_pkg, ccfc_tb_pkg, the interfaces and the monitor

module tb_can_control_frame_checker_unit;
  import ccfc_pkg::*;
  import ccfc_tb_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        gaps_on;
  int          stall_left;
  int          pending;
  int          checked;
  int          passed;
  int          fail_count;
  int          settings_used;
  cfg_t        setting;

  ccfc_frame_if  frame();
  ccfc_result_if result();

  can_control_frame_checker_unit uut (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ccfc_verdict_monitor verdicts (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .result     (result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .checked    (checked),
    .passed     (passed),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls plus an occasional long one to back up the queue
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_left   <= 0;
    end else if (!gaps_on) begin
      result.ready <= 1'b1;
    end else if (stall_left != 0) begin
      result.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(199) == 0) begin
      result.ready <= 1'b0;
      stall_left   <= $urandom_range(40, 15);
    end else begin
      result.ready <= ($urandom_range(99) >= 25);
    end
  end

  task automatic send(can_frame_t f);
    while (gaps_on && $urandom_range(99) < 34) begin
      frame.valid <= 1'b0;
      @(posedge clk);
    end
    frame.valid         <= 1'b1;
    frame.frame_id      <= f.id;
    frame.frame_length  <= f.len;
    frame.extended_flag <= f.ext;
    frame.remote_flag   <= f.rtr;
    frame.payload       <= f.payload;
    @(posedge clk);
    while (!frame.ready) @(posedge clk);
  endtask

  task automatic drain();
    frame.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apply_config(cfg_t s);
    logic [15:0] word [8];
    word[REG_FRAME_ID]  = {5'd0, s.frame_id};
    word[REG_CRC_POLY]  = {8'd0, s.crc_poly};
    word[REG_CRC_INIT]  = {8'd0, s.crc_init};
    word[REG_CRC_XOR]   = {8'd0, s.crc_xor};
    word[REG_SPEED_MIN] = s.speed_min;
    word[REG_SPEED_MAX] = s.speed_max;
    word[REG_YAW_MIN]   = s.yaw_min;
    word[REG_YAW_MAX]   = s.yaw_max;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= word[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    setting = s;
    settings_used++;
  endtask

  // well-formed control frame under the current setting, crc byte filled in
  function automatic can_frame_t cmd(logic [7:0] mode, logic signed [15:0] spd,
                                     logic signed [15:0] yaw, logic [3:0] cnt);
    can_frame_t f;
    f.id  = {18'd0, setting.frame_id};
    f.len = CtrlLength;
    f.ext = 1'b0;
    f.rtr = 1'b0;
    f.payload = {8'h00, CmdValidByte, 4'h0, cnt, mode, yaw, spd};
    f.payload[63:56] = frame_crc(f.id, f.payload, setting);
    return f;
  endfunction

  function automatic logic signed [15:0] pick_value(logic signed [15:0] lo,
                                                    logic signed [15:0] hi);
    int span;
    case ($urandom_range(9))
      0: return lo;
      1: return hi;
      2: return lo - 16'sd1;
      3: return hi + 16'sd1;
      4: return 16'($urandom);
      default: begin
        if (lo > hi) return 16'($urandom);
        span = int'(hi) - int'(lo);
        return 16'(int'(lo) + int'($urandom_range(span)));
      end
    endcase
  endfunction

  function automatic can_frame_t well_formed();
    logic [7:0]         mode;
    logic signed [15:0] spd;
    logic signed [15:0] yaw;
    int                 roll;
    roll = $urandom_range(99);
    mode = (roll < 60) ? 8'd1 : (roll < 90) ? 8'd0 : 8'($urandom);
    spd  = pick_value(setting.speed_min, setting.speed_max);
    yaw  = pick_value(setting.yaw_min, setting.yaw_max);
    // hold frames mostly carry zeros
    if (mode == 8'd0 && $urandom_range(99) < 75) begin
      spd = 16'sd0;
      yaw = 16'sd0;
    end
    return cmd(mode, spd, yaw, 4'($urandom));
  endfunction

  function automatic can_frame_t spoil(can_frame_t f);
    int k;
    case ($urandom_range(8))
      0: f.id = 29'($urandom);
      1: begin
        k = $urandom_range(28);
        f.id[k] = ~f.id[k];
      end
      2: f.len = 4'($urandom);
      3: f.ext = 1'b1;
      4: f.rtr = 1'b1;
      5: begin
        // reserved: bits 7..4 of byte 5 or bits 7..1 of byte 6
        k = $urandom_range(10);
        k = (k < 4) ? 44 + k : 45 + k;
        f.payload[k] = 1'b1;
      end
      6: f.payload[55:48] = 8'h00;
      7: begin
        k = $urandom_range(7);
        f.payload[56 + k] = ~f.payload[56 + k];
      end
      default: f = {29'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
                    $urandom, $urandom};
    endcase
    return f;
  endfunction

  function automatic cfg_t phase_setting(int p);
    cfg_t               s;
    logic signed [15:0] a;
    logic signed [15:0] b;
    s.frame_id = 11'($urandom);
    s.crc_poly = 8'($urandom);
    s.crc_init = 8'($urandom);
    s.crc_xor  = 8'($urandom);
    a = 16'($urandom);
    b = 16'($urandom);
    s.speed_min = (a < b) ? a : b;
    s.speed_max = (a < b) ? b : a;
    a = 16'($urandom);
    b = 16'($urandom);
    s.yaw_min = (a < b) ? a : b;
    s.yaw_max = (a < b) ? b : a;
    case (p)
      0: s = DefaultSetting;
      1: s = '{11'h7FF, 8'hFF, 8'h00, 8'h00, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
      2: begin
        s.frame_id  = 11'd0;
        s.crc_poly  = 8'h00;
        s.speed_min = -16'sd100;
        s.speed_max = 16'sd100;
        s.yaw_min   = -16'sd1;
        s.yaw_max   = 16'sd1;
      end
      4: begin
        // inverted speed window: everything reaching the range check fails
        s.speed_min = 16'sh7FFF;
        s.speed_max = 16'sh8000;
      end
      6: begin
        a = s.yaw_min;
        s.yaw_min = s.yaw_max;
        s.yaw_max = a;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic run_random(int n);
    can_frame_t f;
    for (int i = 0; i < n; i++) begin
      f = well_formed();
      if ($urandom_range(99) < 30) f = spoil(f);
      send(f);
    end
  endtask

  task automatic run_directed();
    can_frame_t f;
    apply_config('{11'h4B3, 8'h1D, 8'hFF, 8'hFF, -16'sd1000, 16'sd1000, -16'sd500, 16'sd500});
    send(cmd(8'd1, 16'sd100, -16'sd50, 4'd3));
    send(cmd(8'd0, 16'sd0, 16'sd0, 4'd15));
    send(cmd(8'd1, -16'sd1000, -16'sd500, 4'd0));
    send(cmd(8'd1, 16'sd1000, 16'sd500, 4'd9));
    send(cmd(8'd1, -16'sd1001, 16'sd0, 4'd1));
    send(cmd(8'd1, 16'sd1001, 16'sd0, 4'd2));
    send(cmd(8'd1, 16'sd0, -16'sd501, 4'd4));
    send(cmd(8'd1, 16'sd0, 16'sd501, 4'd5));
    send(cmd(8'd0, 16'sd5, 16'sd0, 4'd6));
    send(cmd(8'd0, 16'sd0, -16'sd1, 4'd7));
    send(cmd(8'd2, 16'sd0, 16'sd0, 4'd8));
    send(cmd(8'hFF, 16'sd1, 16'sd1, 4'd10));
    f = cmd(8'd1, 16'sd0, 16'sd0, 4'd0);
    f.id[28] = 1'b1;
    send(f);
    f = cmd(8'd1, 16'sd0, 16'sd0, 4'd0);
    f.id[0] = ~f.id[0];
    send(f);
    f = cmd(8'd1, 16'sd0, 16'sd0, 4'd0);
    f.len = 4'd15;
    send(f);
    f.len = 4'd0;
    send(f);
    f = cmd(8'd1, 16'sd0, 16'sd0, 4'd0);
    f.ext = 1'b1;
    send(f);
    f = cmd(8'd1, 16'sd0, 16'sd0, 4'd0);
    f.rtr = 1'b1;
    send(f);
    f = cmd(8'd1, 16'sd0, 16'sd0, 4'd0);
    f.payload[47] = 1'b1;
    send(f);
    f = cmd(8'd1, 16'sd0, 16'sd0, 4'd0);
    f.payload[49] = 1'b1;
    send(f);
    f = cmd(8'd1, 16'sd0, 16'sd0, 4'd0);
    f.payload[55:48] = 8'h00;
    send(f);
    f = cmd(8'd1, 16'sd7, 16'sd7, 4'd0);
    f.payload[63:56] = ~f.payload[63:56];
    send(f);
    // length outranks the extended flag and a bad crc
    f.len = 4'd9;
    f.ext = 1'b1;
    send(f);
    send({29'h1FFFFFFF, 4'hF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF});
    send('0);
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_FRAME_ID;
    cfg_data             <= '0;
    gaps_on              <= 1'b1;
    frame.valid          <= 1'b0;
    frame.frame_id       <= '0;
    frame.frame_length   <= '0;
    frame.extended_flag  <= 1'b0;
    frame.remote_flag    <= 1'b0;
    frame.payload        <= '0;
    settings_used        = 0;
    setting              = DefaultSetting;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < 7; p++) begin
      drain();
      apply_config(phase_setting(p));
      // one phase runs with neither side idling
      gaps_on <= (p != 5);
      run_random(150);
    end
    drain();
    $display("covered %0d frames, %0d of them accepted, under %0d register settings",
             checked, passed, settings_used);
    $display("with random source gaps, sink stalls and one phase at full rate");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
